/* rtl/gtg_pkg.sv */
// shared types, constants and arctangent table for the go-to-goal heading steer
`timescale 1ns / 1ps

package gtg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_IDX_W   = 5;
    localparam int XY_W          = 30;
    localparam int Z_W           = 28;
    localparam int SQ_W          = 33;
    localparam int DIST_W        = 34;
    localparam int TOL_W         = 15;
    localparam int TOL_SQ_W      = 30;

    localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [17:0]    PI_Q13      = 18'sd25736;
    localparam logic signed [17:0]    TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [Z_W-1:0] ROUND_HALF  = 28'sd1024;

    localparam logic [1:0] REG_HEADING_TOL = 2'd0;
    localparam logic [1:0] REG_NEAR_TOL    = 2'd1;
    localparam logic [1:0] REG_REACHED_TOL = 2'd2;
    localparam logic [1:0] REG_CRUISE      = 2'd3;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic signed [15:0]     heading;
        logic [SQ_W-1:0]        dx_sq;
        logic [SQ_W-1:0]        dy_sq;
    } stage_t;

    typedef struct packed {
        logic [TOL_W-1:0]    heading_tol;
        logic [TOL_SQ_W-1:0] near_tol_sq;
        logic [TOL_SQ_W-1:0] reached_tol_sq;
        logic [TOL_W-1:0]    cruise_speed;
    } steer_cfg_t;

    function automatic logic signed [Z_W-1:0] atan_q24(input logic [STAGE_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:  val = 28'sd13176795;
            5'd1:  val = 28'sd7778716;
            5'd2:  val = 28'sd4110060;
            5'd3:  val = 28'sd2086331;
            5'd4:  val = 28'sd1047214;
            5'd5:  val = 28'sd524117;
            5'd6:  val = 28'sd262123;
            5'd7:  val = 28'sd131069;
            5'd8:  val = 28'sd65536;
            5'd9:  val = 28'sd32768;
            5'd10: val = 28'sd16384;
            5'd11: val = 28'sd8192;
            5'd12: val = 28'sd4096;
            5'd13: val = 28'sd2048;
            5'd14: val = 28'sd1024;
            5'd15: val = 28'sd512;
            5'd16: val = 28'sd256;
            5'd17: val = 28'sd128;
            5'd18: val = 28'sd64;
            5'd19: val = 28'sd32;
            5'd20: val = 28'sd16;
            5'd21: val = 28'sd8;
            5'd22: val = 28'sd4;
            5'd23: val = 28'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/go_to_goal_heading_steer_core.sv */
// top level of the go-to-goal heading steer: config registers and stage chain
//
// Input stream (s_*): one pose and goal point per transfer; tdata carries
// pose_x, pose_y, pose_heading, target_x, target_y, 16 bits each, lowest first.
// Output stream (m_*): one steering result per input transfer, in order.
// The stage chain is one entry stage that forms the offset and its squares,
// one cell per cordic micro-rotation, and one output stage that rounds the
// bearing and forms the flags.
// Throughput is one transfer per cycle; every stage has its own valid bit and
// only holds when the stage after it is full and held, so bubbles close up
// and new items still enter while a finished result waits on m_tready.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 heading tolerance, 1 near tolerance, 2 reached tolerance, 3 cruise
// speed); write only while no items are in flight. The squared tolerances
// follow a write through the tolerance registers and then their own squaring registers.
// Reset (aresetn low, synchronous) empties all stages and loads the
// default register values; no clearing pass is needed.
`timescale 1ns / 1ps

module go_to_goal_heading_steer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pose_x, pose_y, pose_heading, target_x, target_y
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // heading_error, oriented, near_goal, goal_reached, forward_valid,
    // forward_speed, zero fill
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wr_data
);

    localparam int N = gtg_pkg::CORDIC_STAGES;

    logic [14:0]                    heading_tol_reg;
    logic [14:0]                    near_tol_reg;
    logic [14:0]                    reached_tol_reg;
    logic [14:0]                    cruise_reg;
    logic [gtg_pkg::TOL_SQ_W-1:0]   near_sq_reg;
    logic [gtg_pkg::TOL_SQ_W-1:0]   reached_sq_reg;
    gtg_pkg::steer_cfg_t            cfg;

    logic                           chain_valid [0:N];
    logic                           chain_ready [0:N];
    gtg_pkg::stage_t                chain_data  [0:N];

    logic signed [15:0]             heading_error;
    logic                           oriented;
    logic                           near_goal;
    logic                           goal_reached;
    logic                           forward_valid;
    logic [14:0]                    forward_speed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heading_tol_reg <= 15'd819;
            near_tol_reg    <= 15'd614;
            reached_tol_reg <= 15'd205;
            cruise_reg      <= 15'd1024;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gtg_pkg::REG_HEADING_TOL: heading_tol_reg <= cfg_wr_data;
                gtg_pkg::REG_NEAR_TOL:    near_tol_reg    <= cfg_wr_data;
                gtg_pkg::REG_REACHED_TOL: reached_tol_reg <= cfg_wr_data;
                gtg_pkg::REG_CRUISE:      cruise_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
        near_sq_reg    <= gtg_pkg::TOL_SQ_W'(near_tol_reg) * gtg_pkg::TOL_SQ_W'(near_tol_reg);
        reached_sq_reg <= gtg_pkg::TOL_SQ_W'(reached_tol_reg)
                          * gtg_pkg::TOL_SQ_W'(reached_tol_reg);
    end

    assign cfg.heading_tol    = heading_tol_reg;
    assign cfg.near_tol_sq    = near_sq_reg;
    assign cfg.reached_tol_sq = reached_sq_reg;
    assign cfg.cruise_speed   = cruise_reg;

    gtg_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pose_x       (s_tdata[15:0]),
        .pose_y       (s_tdata[31:16]),
        .pose_heading (s_tdata[47:32]),
        .target_x     (s_tdata[63:48]),
        .target_y     (s_tdata[79:64]),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_data     (chain_data[0])
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        gtg_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift     (gtg_pkg::STAGE_IDX_W'(i)),
            .atan_step (gtg_pkg::atan_q24(gtg_pkg::STAGE_IDX_W'(i))),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    gtg_finish u_finish (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (chain_valid[N]),
        .in_ready      (chain_ready[N]),
        .in_data       (chain_data[N]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .heading_error (heading_error),
        .oriented      (oriented),
        .near_goal     (near_goal),
        .goal_reached  (goal_reached),
        .forward_valid (forward_valid),
        .forward_speed (forward_speed)
    );

    assign m_tdata = {5'b0, forward_speed, forward_valid, goal_reached, near_goal,
                      oriented, heading_error};

endmodule

/* rtl/gtg_prep.sv */
// entry stage: goal offset, half-plane pre-rotation and squared offsets
`timescale 1ns / 1ps

module gtg_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   pose_x,
    input  logic signed [15:0]   pose_y,
    input  logic signed [15:0]   pose_heading,
    input  logic signed [15:0]   target_x,
    input  logic signed [15:0]   target_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gtg_pkg::stage_t      out_data
);

    logic                  valid_reg;
    gtg_pkg::stage_t       data_reg;
    gtg_pkg::stage_t       data_next;
    logic signed [16:0]    dx;
    logic signed [16:0]    dy;
    logic signed [33:0]    dx_sq_full;
    logic signed [33:0]    dy_sq_full;
    logic signed [gtg_pkg::XY_W-1:0] xw;
    logic signed [gtg_pkg::XY_W-1:0] yw;

    always_comb begin
        dx = 17'(target_x) - 17'(pose_x);
        dy = 17'(target_y) - 17'(pose_y);
        dx_sq_full = 34'(dx) * 34'(dx);
        dy_sq_full = 34'(dy) * 34'(dy);
        xw = gtg_pkg::XY_W'(dx) <<< 8;
        yw = gtg_pkg::XY_W'(dy) <<< 8;
        data_next.zero    = (dx == '0) && (dy == '0);
        data_next.heading = pose_heading;
        data_next.dx_sq   = dx_sq_full[gtg_pkg::SQ_W-1:0];
        data_next.dy_sq   = dy_sq_full[gtg_pkg::SQ_W-1:0];
        data_next.x = xw;
        data_next.y = yw;
        data_next.z = '0;
        if (xw < 0) begin
            if (yw >= 0) begin
                data_next.x = yw;
                data_next.y = -xw;
                data_next.z = gtg_pkg::HALF_PI_Q24;
            end else begin
                data_next.x = -yw;
                data_next.y = xw;
                data_next.z = -gtg_pkg::HALF_PI_Q24;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/gtg_cell.sv */
// one cordic vectoring micro-rotation cell with its own valid and hold logic
`timescale 1ns / 1ps

module gtg_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [gtg_pkg::STAGE_IDX_W-1:0]       shift,
    input  logic signed [gtg_pkg::Z_W-1:0]        atan_step,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  gtg_pkg::stage_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output gtg_pkg::stage_t                       out_data
);

    logic                            valid_reg;
    gtg_pkg::stage_t                 data_reg;
    gtg_pkg::stage_t                 data_next;
    logic signed [gtg_pkg::XY_W-1:0] xs;
    logic signed [gtg_pkg::XY_W-1:0] ys;

    always_comb begin
        xs = in_data.x >>> shift;
        ys = in_data.y >>> shift;
        data_next = in_data;
        if (in_data.y > 0) begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + atan_step;
        end else begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - atan_step;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/gtg_finish.sv */
// output stage: bearing rounding, heading error wrap, tolerance flags, speed
`timescale 1ns / 1ps

module gtg_finish (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gtg_pkg::steer_cfg_t    cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gtg_pkg::stage_t        in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     heading_error,
    output logic                   oriented,
    output logic                   near_goal,
    output logic                   goal_reached,
    output logic                   forward_valid,
    output logic [14:0]            forward_speed
);

    logic                           valid_reg;
    logic signed [15:0]             err_reg;
    logic                           ori_reg;
    logic                           near_reg;
    logic                           reach_reg;
    logic                           fwd_reg;
    logic [14:0]                    speed_reg;

    logic signed [gtg_pkg::Z_W-1:0] acc;
    logic signed [17:0]             bear;
    logic signed [17:0]             err;
    logic signed [17:0]             err_wrap;
    logic signed [17:0]             mag;
    logic [gtg_pkg::DIST_W-1:0]     dist2;
    logic                           ori_next;
    logic                           near_next;
    logic                           reach_next;
    logic                           fwd_next;

    always_comb begin
        acc  = in_data.z + gtg_pkg::ROUND_HALF;
        bear = 18'(acc >>> 11);
        if (bear > gtg_pkg::PI_Q13) begin
            bear = gtg_pkg::PI_Q13;
        end else if (bear < -gtg_pkg::PI_Q13) begin
            bear = -gtg_pkg::PI_Q13;
        end
        if (in_data.zero) begin
            bear = '0;
        end
        err = bear - 18'(in_data.heading);
        if (err > gtg_pkg::PI_Q13) begin
            err_wrap = err - gtg_pkg::TWO_PI_Q13;
        end else if (err < -gtg_pkg::PI_Q13) begin
            err_wrap = err + gtg_pkg::TWO_PI_Q13;
        end else begin
            err_wrap = err;
        end
        mag = (err_wrap < 0) ? -err_wrap : err_wrap;
        ori_next = mag < signed'(18'(cfg.heading_tol));
        dist2 = gtg_pkg::DIST_W'(in_data.dx_sq) + gtg_pkg::DIST_W'(in_data.dy_sq);
        near_next  = dist2 < gtg_pkg::DIST_W'(cfg.near_tol_sq);
        reach_next = dist2 < gtg_pkg::DIST_W'(cfg.reached_tol_sq);
        fwd_next   = ori_next && !near_next;
    end

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign heading_error = err_reg;
    assign oriented      = ori_reg;
    assign near_goal     = near_reg;
    assign goal_reached  = reach_reg;
    assign forward_valid = fwd_reg;
    assign forward_speed = speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            err_reg   <= err_wrap[15:0];
            ori_reg   <= ori_next;
            near_reg  <= near_next;
            reach_reg <= reach_next;
            fwd_reg   <= fwd_next;
            speed_reg <= fwd_next ? cfg.cruise_speed : '0;
        end
    end

endmodule
